>>> sv/ocp_pkg.sv
// Shared types, character codes and result codes of the order message parser.
package ocp_pkg;

  // Characters that steer the parse.
  localparam logic [7:0] CHAR_ADD    = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_CANCEL = 8'h43;  // 'C'
  localparam logic [7:0] CHAR_EXEC   = 8'h45;  // 'E'
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;  // ','
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'

  // Field widths of a command.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned IDENT_W  = 64;
  localparam int unsigned PRICE_W  = 64;
  localparam int unsigned QTY_W    = 32;
  localparam int unsigned SIDE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  // Command kinds.
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXEC   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Position within a message, one-hot.
  typedef enum logic [7:0] {
    PH_TYPE   = 8'b0000_0001,
    PH_SKIP   = 8'b0000_0010,
    PH_IDENT  = 8'b0000_0100,
    PH_PRICE  = 8'b0000_1000,
    PH_QTY    = 8'b0001_0000,
    PH_SIDE   = 8'b0010_0000,
    PH_DONE   = 8'b0100_0000,
    PH_IGNORE = 8'b1000_0000
  } ocp_phase_t;

  // One input byte with its end-of-message flag.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ocp_byte_t;

endpackage

>>> sv/ocp_in_if.sv
// Byte channel: one message character per transaction.
interface ocp_in_if import ocp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

>>> sv/ocp_out_if.sv
// Command channel: one parsed order command per transaction.
interface ocp_out_if import ocp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   msg_kind;
  logic [IDENT_W-1:0]  order_ident;
  logic [PRICE_W-1:0]  limit_price;
  logic [QTY_W-1:0]    quantity;
  logic [SIDE_W-1:0]   side_char;
  logic [STATUS_W-1:0] status;

  modport source (output valid, msg_kind, order_ident, limit_price, quantity, side_char, status,
                  input ready);
  modport sink (input valid, msg_kind, order_ident, limit_price, quantity, side_char, status,
                output ready);
endinterface

>>> sv/order_message_csv_parser_core.sv
// Order message parser: turns a stream of message bytes into order commands.
//
// The bytes channel carries one ASCII character per transaction, with last_byte
// set on the final character of a message. The first character selects add,
// cancel or execute; the second is skipped; comma-separated decimal fields follow.
// On the last byte of a known message one transaction appears on the cmds
// channel with the parsed fields and a status (ok, missing field, overflow);
// messages of any other type produce nothing.
// A command passes through the input register, which takes its last byte, then
// through the parse step into the result register, whose valid drives cmds.
// Throughput: one byte per cycle sustained while cmds is not stalled. The per-byte
// parse step, a multiply-by-ten-and-add on the 64-bit and 32-bit accumulators that
// feeds back into itself, is combinational.
// Reset (synchronous, active high) empties both registers and leaves the
// parser expecting a type byte.
// While the receiver stalls with a command pending, the parser takes no byte;
// an empty input register still takes one more byte, and after that
// bytes.ready stays low until the command leaves.
module order_message_csv_parser_core import ocp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ocp_in_if.sink    bytes,
  ocp_out_if.source cmds
);

  logic      held_valid;
  ocp_byte_t held;
  logic      take;

  // Input register.
  ocp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  // Parse step and result register.
  ocp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held       (held),
    .take       (take),
    .cmds       (cmds)
  );

endmodule

>>> sv/ocp_in_reg.sv
// Input register that holds one byte until the parser takes it.
module ocp_in_reg import ocp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ocp_in_if.sink    bytes,
  input  logic      take,
  output logic      held_valid,
  output ocp_byte_t held
);

  // A new byte may enter when the register is empty or is being emptied.
  assign bytes.ready = !held_valid || take;

  // Valid flag of the held byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (bytes.ready) begin
      held_valid <= bytes.valid;
    end
  end

  // Payload is captured on every accepted transaction.
  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      held.data_byte <= bytes.data_byte;
      held.last_byte <= bytes.last_byte;
    end
  end

endmodule

>>> sv/ocp_parser.sv
// Parse state, per-byte update logic and the command result register.
module ocp_parser import ocp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      held_valid,
  input  ocp_byte_t held,
  output logic      take,
  ocp_out_if.source cmds
);

  ocp_phase_t          phase, phase_upd, phase_next;
  logic [7:0]          kind_held, kind_held_next;
  logic [IDENT_W-1:0]  ident_acc, ident_acc_next;
  logic [PRICE_W-1:0]  price_acc, price_acc_next;
  logic [QTY_W-1:0]    qty_acc, qty_acc_next;
  logic [SIDE_W-1:0]   side_held, side_held_next;
  logic                digit_seen, digit_seen_next;
  logic                run_ended, run_ended_next;
  logic [STATUS_W-1:0] error_held, error_held_next;

  logic [7:0]          b;
  logic                is_digit, is_comma, field_final, kind_now_known, kind_next_known;
  logic [3:0]          digit_val;
  logic [IDENT_W-1:0]  wide_sel, wide_sat;
  logic [IDENT_W+3:0]  wide_prod, wide_ext;
  logic                wide_ovf;
  logic [QTY_W+3:0]    qty_prod, qty_ext;
  logic                qty_ovf;
  logic                complete, emit;
  logic [KIND_W-1:0]   kind_code;
  logic [STATUS_W-1:0] status_code;
  logic                out_free;

  // The parser advances whenever a byte is held and the result slot can be refilled.
  assign out_free = !cmds.valid || cmds.ready;
  assign take     = held_valid && out_free;

  // Byte classification.
  assign b         = held.data_byte;
  assign is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign is_comma  = (b == CHAR_COMMA);
  assign digit_val = 4'(b - CHAR_ZERO);

  assign kind_now_known = (kind_held == CHAR_ADD) || (kind_held == CHAR_CANCEL) ||
                          (kind_held == CHAR_EXEC);
  assign kind_next_known = (kind_held_next == CHAR_ADD) || (kind_held_next == CHAR_CANCEL) ||
                           (kind_held_next == CHAR_EXEC);

  // The closing field of a cancel or execute treats a comma as plain text.
  assign field_final = ((kind_held == CHAR_CANCEL) && (phase == PH_IDENT)) ||
                       ((kind_held == CHAR_EXEC) && (phase == PH_QTY));

  // Multiply-by-ten-and-add for the 64-bit accumulators; carry-out bits flag overflow.
  assign wide_sel  = (phase == PH_IDENT) ? ident_acc : price_acc;
  assign wide_ext  = {4'b0000, wide_sel};
  assign wide_prod = (wide_ext << 3) + (wide_ext << 1) + (IDENT_W + 4)'(digit_val);
  assign wide_ovf  = |wide_prod[IDENT_W+3:IDENT_W];
  assign wide_sat  = wide_ovf ? {IDENT_W{1'b1}} : wide_prod[IDENT_W-1:0];

  // The same step for the 32-bit quantity.
  assign qty_ext  = {4'b0000, qty_acc};
  assign qty_prod = (qty_ext << 3) + (qty_ext << 1) + (QTY_W + 4)'(digit_val);
  assign qty_ovf  = |qty_prod[QTY_W+3:QTY_W];

  // Next parse state for the held byte.
  always_comb begin
    phase_upd       = phase;
    kind_held_next  = kind_held;
    ident_acc_next  = ident_acc;
    price_acc_next  = price_acc;
    qty_acc_next    = qty_acc;
    side_held_next  = side_held;
    digit_seen_next = digit_seen;
    run_ended_next  = run_ended;
    error_held_next = error_held;
    case (phase)
      PH_TYPE: begin
        kind_held_next  = b;
        ident_acc_next  = '0;
        price_acc_next  = '0;
        qty_acc_next    = '0;
        side_held_next  = '0;
        digit_seen_next = 1'b0;
        run_ended_next  = 1'b0;
        error_held_next = ST_OK;
        phase_upd       = PH_SKIP;
      end
      PH_SKIP: begin
        phase_upd = kind_now_known ? PH_IDENT : PH_IGNORE;
      end
      PH_IDENT, PH_PRICE, PH_QTY: begin
        if (is_comma && !field_final) begin
          if (!digit_seen && (error_held == ST_OK)) begin
            error_held_next = ST_MISSING;
          end
          case (phase)
            PH_IDENT: phase_upd = PH_PRICE;
            PH_PRICE: phase_upd = PH_QTY;
            default:  phase_upd = PH_SIDE;
          endcase
          digit_seen_next = 1'b0;
          run_ended_next  = 1'b0;
        end else if (is_digit) begin
          if (!run_ended) begin
            digit_seen_next = 1'b1;
            if (phase == PH_QTY) begin
              qty_acc_next = qty_ovf ? {QTY_W{1'b1}} : qty_prod[QTY_W-1:0];
              if (qty_ovf && (error_held == ST_OK)) begin
                error_held_next = ST_OVERFLOW;
              end
            end else begin
              if (phase == PH_IDENT) begin
                ident_acc_next = wide_sat;
              end else begin
                price_acc_next = wide_sat;
              end
              if (wide_ovf && (error_held == ST_OK)) begin
                error_held_next = ST_OVERFLOW;
              end
            end
          end
        end else begin
          run_ended_next = 1'b1;
        end
      end
      PH_SIDE: begin
        side_held_next = b;
        phase_upd      = PH_DONE;
      end
      default: begin
      end
    endcase
  end

  // Completion check and command assembly on the last byte.
  always_comb begin
    case (kind_held_next)
      CHAR_ADD: begin
        kind_code = KIND_ADD;
        complete  = (phase_upd == PH_DONE);
      end
      CHAR_CANCEL: begin
        kind_code = KIND_CANCEL;
        complete  = (phase_upd == PH_IDENT) && digit_seen_next;
      end
      default: begin
        kind_code = KIND_EXEC;
        complete  = (phase_upd == PH_QTY) && digit_seen_next;
      end
    endcase
    if (error_held_next != ST_OK) begin
      status_code = error_held_next;
    end else if (complete) begin
      status_code = ST_OK;
    end else begin
      status_code = ST_MISSING;
    end
    emit       = held.last_byte && kind_next_known;
    phase_next = held.last_byte ? PH_TYPE : phase_upd;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TYPE;
      kind_held  <= '0;
      ident_acc  <= '0;
      price_acc  <= '0;
      qty_acc    <= '0;
      side_held  <= '0;
      digit_seen <= 1'b0;
      run_ended  <= 1'b0;
      error_held <= ST_OK;
    end else if (take) begin
      phase      <= phase_next;
      kind_held  <= kind_held_next;
      ident_acc  <= ident_acc_next;
      price_acc  <= price_acc_next;
      qty_acc    <= qty_acc_next;
      side_held  <= side_held_next;
      digit_seen <= digit_seen_next;
      run_ended  <= run_ended_next;
      error_held <= error_held_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmds.valid <= 1'b0;
    end else if (take) begin
      cmds.valid <= emit;
    end else if (cmds.ready) begin
      cmds.valid <= 1'b0;
    end
  end

  // Result payload; fields the kind does not use read as zero.
  always_ff @(posedge clk) begin
    if (take && emit) begin
      cmds.msg_kind    <= kind_code;
      cmds.order_ident <= ident_acc_next;
      cmds.limit_price <= (kind_code == KIND_ADD) ? price_acc_next : '0;
      cmds.quantity    <= (kind_code != KIND_CANCEL) ? qty_acc_next : '0;
      cmds.side_char   <= (kind_code == KIND_ADD) ? side_held_next : '0;
      cmds.status      <= status_code;
    end
  end

  // A transaction that emits a command always leaves the parser waiting for a type byte.
  a_emit_rearms: assert property (@(posedge clk) disable iff (rst)
    take && emit |=> phase == PH_TYPE)
    else $error("parser did not return to the type byte after a command");

  // A byte that is not the last of a message never produces a command.
  a_no_early_cmd: assert property (@(posedge clk) disable iff (rst)
    take && !held.last_byte |=> !cmds.valid)
    else $error("command produced before the last byte");

  // Price and side belong to add commands only.
  a_add_fields: assert property (@(posedge clk) disable iff (rst)
    cmds.valid && (cmds.msg_kind != KIND_ADD) |-> (cmds.limit_price == '0) &&
    (cmds.side_char == '0))
    else $error("price or side set on a non-add command");

  // A cancel carries no quantity.
  a_cancel_qty: assert property (@(posedge clk) disable iff (rst)
    cmds.valid && (cmds.msg_kind == KIND_CANCEL) |-> cmds.quantity == '0)
    else $error("quantity set on a cancel command");

endmodule

>>> tb/sv/order_message_csv_parser_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the order message parser, with a byte-level predictor.
module order_message_csv_parser_core_tb;
  import ocp_pkg::*;

  // Worst case is roughly 1700 bytes each followed by the longest idle gap, a few hundred
  // commands each held by the longest stall and one long hold-off, well under CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [IDENT_W-1:0]  ident;
    logic [PRICE_W-1:0]  price;
    logic [QTY_W-1:0]    qty;
    logic [SIDE_W-1:0]   side;
    logic [STATUS_W-1:0] status;
  } order_cmd_t;

  logic clk;
  logic rst;

  ocp_in_if  bytes_if ();
  ocp_out_if cmds_if ();

  order_message_csv_parser_core u_top (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes_if),
    .cmds  (cmds_if)
  );

  // Commands predicted but not yet seen on the output.
  order_cmd_t  pending_cmds[$];
  order_cmd_t  oldest_cmd;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          idle_on     = 1'b0;
  bit          hold_req    = 1'b0;

  // Directed messages, with the command typed in where it is obvious.
  string       dir_text[$];
  bit          dir_typed[$];
  order_cmd_t  dir_cmd[$];

  // Parser state as the predictor sees it.
  ocp_phase_t  phase_p  = PH_TYPE;
  logic [7:0]  kind_p   = '0;
  logic [63:0] ident_p  = '0;
  logic [63:0] price_p  = '0;
  logic [31:0] qty_p    = '0;
  logic [7:0]  side_p   = '0;
  logic        digit_p  = 1'b0;
  logic [1:0]  error_p  = ST_OK;
  logic        ended_p  = 1'b0;

  // The clock runs freely from time zero.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit kind_is_known(input logic [7:0] k);
    return k == CHAR_ADD || k == CHAR_CANCEL || k == CHAR_EXEC;
  endfunction

  // Advances the predicted parser by one byte and reports the command it emits, if any.
  function automatic bit parse_byte(input logic [7:0] b, input logic lst,
                                    output order_cmd_t cmd);
    logic [67:0] wide;
    logic [35:0] wide_qty;
    logic [63:0] acc;
    logic [3:0]  digit;
    bit          closing;
    bit          complete;

    cmd      = '0;
    digit    = 4'(b - CHAR_ZERO);
    // In the field that closes a cancel or an execute, a comma only ends the number.
    closing  = (kind_p == CHAR_CANCEL && phase_p == PH_IDENT) ||
               (kind_p == CHAR_EXEC && phase_p == PH_QTY);
    case (phase_p)
      PH_TYPE: begin
        kind_p  = b;
        ident_p = '0;
        price_p = '0;
        qty_p   = '0;
        side_p  = '0;
        digit_p = 1'b0;
        ended_p = 1'b0;
        error_p = ST_OK;
        phase_p = PH_SKIP;
      end
      PH_SKIP: begin
        phase_p = kind_is_known(kind_p) ? PH_IDENT : PH_IGNORE;
      end
      PH_IDENT, PH_PRICE, PH_QTY: begin
        if (b == CHAR_COMMA && !closing) begin
          if (!digit_p && error_p == ST_OK) error_p = ST_MISSING;
          case (phase_p)
            PH_IDENT: phase_p = PH_PRICE;
            PH_PRICE: phase_p = PH_QTY;
            default:  phase_p = PH_SIDE;
          endcase
          digit_p = 1'b0;
          ended_p = 1'b0;
        end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          if (!ended_p) begin
            // Multiply by ten and add, saturating at all ones on overflow.
            if (phase_p == PH_QTY) begin
              wide_qty = {4'd0, qty_p} * 36'd10 + 36'(digit);
              if (wide_qty[35:32] != '0) begin
                qty_p = '1;
                if (error_p == ST_OK) error_p = ST_OVERFLOW;
              end else begin
                qty_p = wide_qty[31:0];
              end
            end else begin
              acc  = (phase_p == PH_IDENT) ? ident_p : price_p;
              wide = {4'd0, acc} * 68'd10 + 68'(digit);
              if (wide[67:64] != '0) begin
                acc = '1;
                if (error_p == ST_OK) error_p = ST_OVERFLOW;
              end else begin
                acc = wide[63:0];
              end
              if (phase_p == PH_IDENT) ident_p = acc;
              else price_p = acc;
            end
            digit_p = 1'b1;
          end
        end else begin
          ended_p = 1'b1;
        end
      end
      PH_SIDE: begin
        side_p  = b;
        phase_p = PH_DONE;
      end
      default: ;
    endcase

    if (!lst) return 1'b0;
    if (!kind_is_known(kind_p)) begin
      phase_p = PH_TYPE;
      return 1'b0;
    end

    // Build the command from what was parsed, zeroing fields the kind does not use.
    case (kind_p)
      CHAR_ADD: begin
        cmd.kind = KIND_ADD;
        complete = phase_p == PH_DONE;
      end
      CHAR_CANCEL: begin
        cmd.kind = KIND_CANCEL;
        complete = phase_p == PH_IDENT && digit_p;
      end
      default: begin
        cmd.kind = KIND_EXEC;
        complete = phase_p == PH_QTY && digit_p;
      end
    endcase
    cmd.status = (error_p == ST_OK && !complete) ? ST_MISSING : error_p;
    cmd.ident  = ident_p;
    cmd.price  = (cmd.kind == KIND_ADD) ? price_p : '0;
    cmd.qty    = (cmd.kind != KIND_CANCEL) ? qty_p : '0;
    cmd.side   = (cmd.kind == KIND_ADD) ? side_p : '0;
    phase_p    = PH_TYPE;
    return 1'b1;
  endfunction

  function automatic void add_dir(input string text, input bit typed, input order_cmd_t cmd);
    dir_text.push_back(text);
    dir_typed.push_back(typed);
    dir_cmd.push_back(cmd);
  endfunction

  // Appends a decimal field: mostly short, sometimes empty, sometimes long enough to overflow.
  function automatic void append_field(ref logic [7:0] msg[$], input bit narrow);
    int unsigned pick;
    int unsigned ndig;
    int unsigned junk_at;

    pick = $urandom_range(0, 99);
    if (pick < 8) ndig = 0;
    else if (pick < 88) ndig = $urandom_range(1, narrow ? 9 : 12);
    else ndig = narrow ? $urandom_range(9, 11) : $urandom_range(18, 21);
    junk_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, ndig) : ndig + 1;
    for (int unsigned i = 0; i <= ndig; i++) begin
      if (i == junk_at) msg.push_back(8'($urandom_range(0, 255)));
      if (i < ndig) msg.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  // Builds one random message: mostly well formed, with noise and broken messages mixed in.
  function automatic void make_message(output logic [7:0] msg[$]);
    int unsigned pick;
    int unsigned nfields;
    int unsigned qty_field;
    logic [7:0]  kind;

    msg  = {};
    pick = $urandom_range(0, 99);
    if (pick >= 92) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 30) begin
      kind = CHAR_ADD;
      nfields = 3;
      qty_field = 2;
    end else if (pick < 55) begin
      kind = CHAR_CANCEL;
      nfields = 1;
      qty_field = 9;
    end else if (pick < 82) begin
      kind = CHAR_EXEC;
      nfields = ($urandom_range(0, 4) == 0) ? 2 : 3;
      qty_field = nfields - 1;
    end else begin
      do kind = 8'($urandom_range(0, 255)); while (kind_is_known(kind));
      nfields = $urandom_range(0, 3);
      qty_field = 9;
    end
    msg.push_back(kind);
    msg.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CHAR_COMMA);
    for (int unsigned f = 0; f < nfields; f++) begin
      if (f > 0 && $urandom_range(0, 19) != 0) msg.push_back(CHAR_COMMA);
      append_field(msg, f == qty_field);
    end
    if (kind == CHAR_ADD) begin
      if ($urandom_range(0, 19) != 0) msg.push_back(CHAR_COMMA);
      case ($urandom_range(0, 3))
        0:       msg.push_back("B");
        1:       msg.push_back("S");
        default: msg.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 5)) msg.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 15) == 0)
      msg = msg[0:$urandom_range(0, msg.size() - 1)];
  endfunction

  // Offers the bytes of one message; each accepted byte goes through the predictor.
  task automatic send_message(input logic [7:0] msg[$], input bit typed,
                              input order_cmd_t typed_cmd);
    order_cmd_t cmd;
    bit         lst;

    foreach (msg[i]) begin
      lst = (i == msg.size() - 1);
      bytes_if.valid     <= 1'b1;
      bytes_if.data_byte <= msg[i];
      bytes_if.last_byte <= lst;
      @(posedge clk);
      while (!bytes_if.ready) @(posedge clk);
      if (parse_byte(msg[i], lst, cmd)) pending_cmds.push_back(typed ? typed_cmd : cmd);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        bytes_if.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] expected,
                             input logic [63:0] actual);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      mismatches++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request so that the parser backs up.
  initial begin
    cmds_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      if (hold_req) begin
        cmds_if.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        cmds_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        cmds_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Each command transaction is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && cmds_if.valid && cmds_if.ready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, actual kind %0d ident %h status %0d",
                 $time, cmds_if.msg_kind, cmds_if.order_ident, cmds_if.status);
        mismatches++;
      end else begin
        oldest_cmd = pending_cmds.pop_front();
        check_field("msg_kind", 64'(oldest_cmd.kind), 64'(cmds_if.msg_kind));
        check_field("order_ident", oldest_cmd.ident, cmds_if.order_ident);
        check_field("limit_price", oldest_cmd.price, cmds_if.limit_price);
        check_field("quantity", 64'(oldest_cmd.qty), 64'(cmds_if.quantity));
        check_field("side_char", 64'(oldest_cmd.side), 64'(cmds_if.side_char));
        check_field("status", 64'(oldest_cmd.status), 64'(cmds_if.status));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("order_message_csv_parser_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [7:0]  msg[$];
    int unsigned sent;
    int unsigned n_msgs;
    bit          hold_done;

    rst                = 1'b1;
    bytes_if.valid     = 1'b0;
    bytes_if.data_byte = '0;
    bytes_if.last_byte = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed messages: plain commands, field extremes and each malformed shape.
    add_dir("A,123,4567,89,B", 1'b1, {KIND_ADD, 64'd123, 64'd4567, 32'd89, "B", ST_OK});
    add_dir("C,42", 1'b1, {KIND_CANCEL, 64'd42, 64'd0, 32'd0, 8'd0, ST_OK});
    add_dir("E,7,0,15", 1'b1, {KIND_EXEC, 64'd7, 64'd0, 32'd15, 8'd0, ST_OK});
    add_dir("E,7,15", 1'b1, {KIND_EXEC, 64'd7, 64'd0, 32'd0, 8'd0, ST_MISSING});
    add_dir("C,18446744073709551615", 1'b1,
            {KIND_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0, 8'd0, ST_OK});
    add_dir("C,18446744073709551616", 1'b1,
            {KIND_CANCEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0, 8'd0, ST_OVERFLOW});
    add_dir("A,1,2,4294967295,S", 1'b1,
            {KIND_ADD, 64'd1, 64'd2, 32'hFFFF_FFFF, "S", ST_OK});
    add_dir("E,9,1,4294967296", 1'b1,
            {KIND_EXEC, 64'd9, 64'd0, 32'hFFFF_FFFF, 8'd0, ST_OVERFLOW});
    add_dir("A,1,2,3,\377", 1'b1, {KIND_ADD, 64'd1, 64'd2, 32'd3, 8'hFF, ST_OK});
    add_dir("A", 1'b1, {KIND_ADD, 64'd0, 64'd0, 32'd0, 8'd0, ST_MISSING});
    add_dir("A,12x34,5,6,B", 1'b0, '0);
    add_dir("A, 5,6,7,S", 1'b0, '0);
    add_dir("C,+7", 1'b0, '0);
    add_dir("C,", 1'b0, '0);
    add_dir("A,1,2", 1'b0, '0);
    add_dir("E,3,,4", 1'b0, '0);
    add_dir("E,,3,4", 1'b0, '0);
    add_dir("C,5,,,x", 1'b0, '0);
    add_dir("A,1,2,3,SZZ,9", 1'b0, '0);
    add_dir("A,,99999999999999999999,1,B", 1'b0, '0);
    add_dir("X,1,2", 1'b0, '0);
    add_dir("Z\377", 1'b0, '0);

    idle_on = 1'b1;
    foreach (dir_text[r]) begin
      msg = {};
      for (int i = 0; i < dir_text[r].len(); i++) msg.push_back(dir_text[r][i]);
      send_message(msg, dir_typed[r], dir_cmd[r]);
    end

    // Random messages; idling comes and goes in stretches and stops for the last quarter.
    sent      = 0;
    n_msgs    = 0;
    hold_done = 1'b0;
    while (sent < RANDOM_BYTES) begin
      if (n_msgs % 8 == 0)
        idle_on = (sent < RANDOM_BYTES * 3 / 4) && ($urandom_range(0, 9) < 7);
      if (!hold_done && sent >= RANDOM_BYTES / 2) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      make_message(msg);
      send_message(msg, 1'b0, '0);
      sent += msg.size();
      n_msgs++;
    end
    idle_on = 1'b0;
    bytes_if.valid <= 1'b0;

    // Drain outstanding commands, then watch a little longer for strays.
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("order_message_csv_parser_core regression: pass");
    else
      $display("order_message_csv_parser_core regression: fail");
    $finish;
  end

endmodule

>>> order_message_csv_parser_core.f
sv/ocp_pkg.sv
sv/ocp_in_if.sv
sv/ocp_out_if.sv
sv/ocp_in_reg.sv
sv/ocp_parser.sv
sv/order_message_csv_parser_core.sv
tb/sv/order_message_csv_parser_core_tb.sv
